/* sv/ssw_pkg.sv */
package ssw_pkg;

  localparam logic [4:0] MAX_SERVOS = 5'd20;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  localparam logic [7:0]  SYNC_BYTE        = 8'hFF;
  localparam logic [7:0]  BROADCAST_ID     = 8'hFE;
  localparam logic [7:0]  INSTR_SYNC       = 8'h83;
  localparam logic [7:0]  START_REG        = 8'd41;
  localparam logic [7:0]  BYTES_PER_RECORD = 8'd7;
  localparam logic [7:0]  LEN_OFFSET       = 8'd4;
  localparam logic [7:0]  TIME_BYTE        = 8'h00;
  localparam logic [15:0] DIR_BIT          = 16'h8000;

  typedef enum logic [3:0] {
    STEP_SYNC0   = 4'd0,
    STEP_SYNC1   = 4'd1,
    STEP_BCAST   = 4'd2,
    STEP_LEN     = 4'd3,
    STEP_INSTR   = 4'd4,
    STEP_REG     = 4'd5,
    STEP_NBYTES  = 4'd6,
    STEP_ID      = 4'd7,
    STEP_ACC     = 4'd8,
    STEP_POS_LO  = 4'd9,
    STEP_POS_HI  = 4'd10,
    STEP_TIME_LO = 4'd11,
    STEP_TIME_HI = 4'd12,
    STEP_SPD_LO  = 4'd13,
    STEP_SPD_HI  = 4'd14,
    STEP_CSUM    = 4'd15
  } step_e;

  typedef struct packed {
    logic [7:0]         servo_id;
    logic signed [15:0] position;
    logic [15:0]        speed;
    logic [7:0]         accel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  servo_id;
    logic [15:0] pos_code;
    logic [15:0] speed;
    logic [7:0]  accel;
    logic [7:0]  len_byte;
    logic        hdr;
    logic        last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [4:0] eff_count(logic [4:0] c);
    logic [4:0] r;
    if (c == 5'd0) begin
      r = 5'd1;
    end else if (c > MAX_SERVOS) begin
      r = MAX_SERVOS;
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [15:0] pos_encode(logic signed [15:0] p);
    logic [15:0] r;
    if (p[15]) begin
      r = (16'(0) - 16'(p)) | DIR_BIT;
    end else begin
      r = 16'(p);
    end
    return r;
  endfunction

endpackage

/* sv/ssw_front.sv */
module ssw_front
  import ssw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data_i,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data_i,
  input  queue_stat_t q_stat_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [4:0] servo_count_q, servo_count_d;
  logic [4:0] record_idx_q, record_idx_d;
  logic [4:0] latched_cnt_q, latched_cnt_d;
  logic [4:0] cnt_use;
  logic [4:0] idx_inc;
  logic       hdr;
  logic       last;

  assign in_ready  = !q_stat_i.full;
  assign cfg_ready = 1'b1;
  assign push_o    = in_valid && in_ready;

  assign hdr     = (record_idx_q == 5'd0);
  assign cnt_use = hdr ? eff_count(servo_count_q) : latched_cnt_q;
  assign idx_inc = record_idx_q + 5'd1;
  assign last    = (idx_inc >= cnt_use);

  always_comb begin
    job_o.servo_id = in_data_i.servo_id;
    job_o.pos_code = pos_encode(in_data_i.position);
    job_o.speed    = in_data_i.speed;
    job_o.accel    = in_data_i.accel;
    job_o.len_byte = {cnt_use, 3'b000} + LEN_OFFSET;
    job_o.hdr      = hdr;
    job_o.last     = last;
  end

  always_comb begin
    servo_count_d = servo_count_q;
    record_idx_d  = record_idx_q;
    latched_cnt_d = latched_cnt_q;
    if (cfg_valid && cfg_ready) begin
      servo_count_d = cfg_data_i;
    end
    if (push_o) begin
      latched_cnt_d = cnt_use;
      record_idx_d  = last ? 5'd0 : idx_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_count_q <= 5'd1;
      record_idx_q  <= 5'd0;
      latched_cnt_q <= 5'd1;
    end else begin
      servo_count_q <= servo_count_d;
      record_idx_q  <= record_idx_d;
      latched_cnt_q <= latched_cnt_d;
    end
  end

endmodule

/* sv/ssw_queue.sv */
module ssw_queue
  import ssw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  job_t        job_i,
  input  logic        pop_i,
  output job_t        job_o,
  output queue_stat_t stat_o
);

  job_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]     count_q, count_d;

  assign stat_o.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign job_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (FIFO_AW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* sv/ssw_back.sv */
module ssw_back
  import ssw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        job_i,
  input  queue_stat_t q_stat_i,
  output logic        pop_o,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data_o
);

  job_t       job_q, job_d;
  step_e      step_q, step_d;
  logic       busy_q, busy_d;
  logic [7:0] sum_q, sum_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic       emit;
  logic       final_byte;
  logic       load;
  logic [7:0] cur_byte;
  logic       summed;

  assign emit       = busy_q && (!out_valid_q || out_ready);
  assign final_byte = (step_q == STEP_CSUM) || ((step_q == STEP_SPD_HI) && !job_q.last);
  assign load       = !q_stat_i.empty && (!busy_q || (emit && final_byte));
  assign pop_o      = load;

  always_comb begin
    summed = 1'b1;
    unique case (step_q)
      STEP_SYNC0: begin
        cur_byte = SYNC_BYTE;
        summed   = 1'b0;
      end
      STEP_SYNC1: begin
        cur_byte = SYNC_BYTE;
        summed   = 1'b0;
      end
      STEP_BCAST:   cur_byte = BROADCAST_ID;
      STEP_LEN:     cur_byte = job_q.len_byte;
      STEP_INSTR:   cur_byte = INSTR_SYNC;
      STEP_REG:     cur_byte = START_REG;
      STEP_NBYTES:  cur_byte = BYTES_PER_RECORD;
      STEP_ID:      cur_byte = job_q.servo_id;
      STEP_ACC:     cur_byte = job_q.accel;
      STEP_POS_LO:  cur_byte = job_q.pos_code[7:0];
      STEP_POS_HI:  cur_byte = job_q.pos_code[15:8];
      STEP_TIME_LO: cur_byte = TIME_BYTE;
      STEP_TIME_HI: cur_byte = TIME_BYTE;
      STEP_SPD_LO:  cur_byte = job_q.speed[7:0];
      STEP_SPD_HI:  cur_byte = job_q.speed[15:8];
      STEP_CSUM: begin
        cur_byte = ~sum_q;
        summed   = 1'b0;
      end
      default: begin
        cur_byte = '0;
        summed   = 1'b0;
      end
    endcase
  end

  always_comb begin
    job_d       = job_q;
    step_d      = step_q;
    busy_d      = busy_q;
    sum_d       = sum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d      = 1'b1;
      out_d.out_byte   = cur_byte;
      out_d.packet_end = (step_q == STEP_CSUM);
      out_d.run_end    = final_byte;
      if (step_q == STEP_SYNC0 || step_q == STEP_CSUM) begin
        sum_d = '0;
      end else if (summed) begin
        sum_d = sum_q + cur_byte;
      end
      step_d = step_e'(4'(step_q) + 4'd1);
      if (final_byte) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      job_d  = job_i;
      busy_d = 1'b1;
      step_d = job_i.hdr ? STEP_SYNC0 : STEP_ID;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_SYNC0;
      busy_q      <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      busy_q      <= busy_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid  = out_valid_q;
  assign out_data_o = out_q;

endmodule

/* sv/servo_sync_write_framer_unit.sv */
// Sync-write packet framer: each accepted servo record comes out as a run of bytes, one byte per
// clock while the output side takes them. A record inside a packet gives 8 bytes. The record
// that closes a packet gives 9, with the checksum after it. The first record of a packet gives
// 15, with the header in front. A first record that also closes the packet gives 16. A record
// therefore gives 8 to 16 bytes, paced by the back-end byte sequencer, and a queued next record
// follows with no gap. A two-entry record queue sits between the input side and the
// sequencer, so records are taken while earlier ones are still being sent. The record count per
// packet is read from the count register when a packet starts; 0 counts as 1 and anything above
// 20 as 20.
module servo_sync_write_framer_unit
  import ssw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data_i,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data_o,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data_i
);

  queue_stat_t q_stat;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        head_job;

  ssw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data_i  (in_data_i),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data_i (cfg_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (push_job)
  );

  ssw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  ssw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (head_job),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data_o (out_data_o)
  );

  a_pkt_end_is_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data_o.packet_end |-> out_data_o.run_end)
    else $error("checksum byte not marked as end of run");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("record taken from empty queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("record written into full queue");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> !q_stat.empty)
    else $error("queue empty after a record was written");

endmodule

/* bench/tb_servo_sync_write_framer_unit.sv */
module tb_servo_sync_write_framer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ssw_pkg::*;

  localparam int RUN_LIMIT     = 1_500_000;
  localparam int RECORD_TARGET = 420;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 50;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  in_item_t   in_data_i  = '0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data_i = '0;

  // model of the framer as seen from the ports
  logic [4:0] count_reg    = 5'd1;
  logic [4:0] record_idx   = 5'd0;
  logic [4:0] packet_count = 5'd1;
  logic [7:0] frame_sum    = 8'd0;
  out_item_t  byte_queue[$];

  int    error_count  = 0;
  int    records_sent = 0;
  int    stall_left   = 0;
  longint cycle_count = 0;
  bit    no_idle      = 1'b0;
  bit    sink_hold    = 1'b0;
  event  hold_start;

  servo_sync_write_framer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data_i  (in_data_i),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data_o (out_data_o),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic void queue_byte(logic [7:0] b, bit summed, bit pkt_end, bit run_last);
    out_item_t e;
    e.out_byte   = b;
    e.packet_end = pkt_end;
    e.run_end    = run_last;
    byte_queue.push_back(e);
    if (summed) begin
      frame_sum = frame_sum + b;
    end
  endfunction

  function automatic void frame_record(in_item_t rec);
    logic [15:0] raw;
    logic [15:0] pos_code;
    logic [7:0]  len_byte;
    bit          closes;
    raw = rec.position;
    pos_code = raw[15] ? ((~raw + 16'd1) | DIR_BIT) : raw;
    if (record_idx == 5'd0) begin
      if (count_reg == 5'd0) begin
        packet_count = 5'd1;
      end else if (count_reg > MAX_SERVOS) begin
        packet_count = MAX_SERVOS;
      end else begin
        packet_count = count_reg;
      end
      frame_sum = 8'd0;
      len_byte = {3'b000, packet_count} * (BYTES_PER_RECORD + 8'd1) + LEN_OFFSET;
      queue_byte(SYNC_BYTE, 1'b0, 1'b0, 1'b0);
      queue_byte(SYNC_BYTE, 1'b0, 1'b0, 1'b0);
      queue_byte(BROADCAST_ID, 1'b1, 1'b0, 1'b0);
      queue_byte(len_byte, 1'b1, 1'b0, 1'b0);
      queue_byte(INSTR_SYNC, 1'b1, 1'b0, 1'b0);
      queue_byte(START_REG, 1'b1, 1'b0, 1'b0);
      queue_byte(BYTES_PER_RECORD, 1'b1, 1'b0, 1'b0);
    end
    record_idx = record_idx + 5'd1;
    closes = (record_idx >= packet_count);
    queue_byte(rec.servo_id, 1'b1, 1'b0, 1'b0);
    queue_byte(rec.accel, 1'b1, 1'b0, 1'b0);
    queue_byte(pos_code[7:0], 1'b1, 1'b0, 1'b0);
    queue_byte(pos_code[15:8], 1'b1, 1'b0, 1'b0);
    queue_byte(TIME_BYTE, 1'b1, 1'b0, 1'b0);
    queue_byte(TIME_BYTE, 1'b1, 1'b0, 1'b0);
    queue_byte(rec.speed[7:0], 1'b1, 1'b0, 1'b0);
    queue_byte(rec.speed[15:8], 1'b1, 1'b0, !closes);
    if (closes) begin
      queue_byte(~frame_sum, 1'b0, 1'b1, 1'b1);
      record_idx = 5'd0;
    end
  endfunction

  function automatic in_item_t random_record();
    in_item_t r;
    r.servo_id = 8'($urandom_range(0, 255));
    r.accel    = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: r.position = 16'h7fff;
      1: r.position = 16'h8001;
      2: r.position = 16'h8000;
      3: r.position = 16'hffff;
      default: r.position = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 9))
      0: r.speed = 16'h0000;
      1: r.speed = 16'hffff;
      default: r.speed = 16'($urandom_range(0, 65535));
    endcase
    return r;
  endfunction

  // prediction and checking, both at the sampling edge
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        count_reg = cfg_data_i;
      end
      if (in_valid && in_ready) begin
        frame_record(in_data_i);
      end
      if (out_valid && out_ready) begin
        if (byte_queue.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected byte, expected none, actual %h end=%b run=%b", $realtime,
                     out_data_o.out_byte, out_data_o.packet_end, out_data_o.run_end);
          end
        end else begin
          want = byte_queue.pop_front();
          if (out_data_o.out_byte !== want.out_byte || out_data_o.packet_end !== want.packet_end
              || out_data_o.run_end !== want.run_end) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("%0t: mismatch, expected %h end=%b run=%b, actual %h end=%b run=%b",
                       $realtime, want.out_byte, want.packet_end, want.run_end,
                       out_data_o.out_byte, out_data_o.packet_end, out_data_o.run_end);
            end
          end
        end
      end
    end
  end

  // output side stalls
  always @(posedge clk_i) begin
    if (sink_hold || stall_left > 0) begin
      out_ready <= 1'b0;
      if (!sink_hold && stall_left > 0) begin
        stall_left--;
      end
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left = pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // long output hold, counted here
  initial begin
    forever begin
      @(hold_start);
      sink_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      sink_hold = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_record(input in_item_t rec);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_data_i <= rec;
    do @(posedge clk_i); while (!in_ready);
    records_sent++;
  endtask

  task automatic wait_frames_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (byte_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_servo_count(input logic [4:0] value);
    wait_frames_drained();
    cfg_valid  <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_records(input int n);
    for (int i = 0; i < n; i++) begin
      send_record(random_record());
    end
  endtask

  // reset count of one, every field at its limits, most negative position
  task automatic test_field_extremes();
    send_record('{servo_id: 8'h00, position: 16'sh0000, speed: 16'h0000, accel: 8'h00});
    send_record('{servo_id: 8'hff, position: 16'sh7fff, speed: 16'hffff, accel: 8'hff});
    send_record('{servo_id: 8'h01, position: -16'sd32767, speed: 16'h0001, accel: 8'h01});
    send_record('{servo_id: 8'h80, position: 16'sh8000, speed: 16'h8000, accel: 8'h80});
    send_record('{servo_id: 8'h55, position: -16'sd1, speed: 16'h00ff, accel: 8'haa});
    send_record('{servo_id: 8'haa, position: 16'sh5555, speed: 16'hff00, accel: 8'h55});
  endtask

  task automatic test_zero_count();
    write_servo_count(5'd0);
    send_random_records(2);
  endtask

  // new count lands while a packet is open
  task automatic test_count_change_mid_packet();
    write_servo_count(5'd3);
    send_random_records(2);
    write_servo_count(5'd1);
    send_random_records(2);
  endtask

  task automatic test_count_limits();
    write_servo_count(MAX_SERVOS);
    send_random_records(int'(MAX_SERVOS));
    write_servo_count(5'd31);
    send_random_records(int'(MAX_SERVOS));
  endtask

  task automatic test_output_hold();
    write_servo_count(5'd4);
    no_idle = 1'b1;
    -> hold_start;
    send_random_records(10);
    no_idle = 1'b0;
  endtask

  task automatic test_random_packets();
    logic [4:0] value;
    int         eff;
    int         n;
    while (records_sent < RECORD_TARGET) begin
      case ($urandom_range(0, 9))
        0: value = 5'd0;
        1: value = 5'd1;
        2: value = MAX_SERVOS;
        3: value = 5'($urandom_range(21, 31));
        default: value = 5'($urandom_range(2, 19));
      endcase
      eff = (value == 5'd0) ? 1 : ((value > MAX_SERVOS) ? int'(MAX_SERVOS) : int'(value));
      if ($urandom_range(0, 9) < 7) begin
        n = eff * $urandom_range(1, 2);
      end else begin
        n = $urandom_range(1, eff + 3);
      end
      write_servo_count(value);
      no_idle = ($urandom_range(0, 4) == 0);
      send_random_records(n);
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_zero_count();
    test_count_change_mid_packet();
    test_count_limits();
    test_output_hold();
    test_random_packets();
    wait_frames_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && byte_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* servo_sync_write_framer_unit.f */
sv/ssw_pkg.sv
sv/ssw_front.sv
sv/ssw_queue.sv
sv/ssw_back.sv
sv/servo_sync_write_framer_unit.sv
bench/tb_servo_sync_write_framer_unit.sv
